### sv/mfer_pkg.sv
// Shared types and constants for the edge-replicating median filter.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package mfer_pkg;

  localparam int KSIZE_DEF      = 3;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT     = 2048;
  localparam int MAX_RESULTS    = 4;
  localparam int QDEPTH         = 128;
  localparam int ENTRY_DEPTH    = 256;
  localparam int JOB_DEPTH      = 32;
  localparam int GRANT_DEPTH    = 32;
  localparam int CHANNELS       = 3;

  localparam int CH_W    = 8;
  localparam int PIX_W   = CHANNELS * CH_W;
  localparam int COORD_W = 11;
  localparam int DIM_W   = 12;
  localparam int SPAN_W  = 3;
  localparam int EFF_W   = 6;
  localparam int GNT_W   = 3;
  localparam int VQ_W    = 8;

  localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;

  typedef logic [PIX_W-1:0] pix_t;

  // One median and the block of output positions it fills.
  typedef struct packed {
    logic [COORD_W-1:0] r0;
    logic [COORD_W-1:0] c0;
    logic [SPAN_W-1:0]  cspan;
    logic [EFF_W-1:0]   eff;
  } job_geom_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    pix_t               pix;
  } res_entry_t;

  typedef struct packed {
    logic job_pop;
    logic gnt_pop;
  } q_stat_t;

endpackage
`default_nettype wire

### sv/mfer_line_buf.sv
// Line store memory and sliding window registers of the median filter.
// Depends on mfer_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mfer_line_buf #(
  parameter int KSIZE     = mfer_pkg::KSIZE_DEF,
  parameter int MAX_WIDTH = mfer_pkg::MAX_WIDTH_DEF,
  localparam int HALF     = (KSIZE - 1) / 2,
  localparam int WIN      = 2 * HALF + 1,
  localparam int NE       = WIN * WIN,
  localparam int LB_DEPTH = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096,
  localparam int AW       = $clog2(LB_DEPTH),
  localparam int SLW      = $clog2(KSIZE)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       acc,
  input  wire logic [AW-1:0]              col,
  input  wire logic [SLW-1:0]             slot,
  input  wire mfer_pkg::pix_t             pix,
  output mfer_pkg::pix_t [NE-1:0]         win
);

  mfer_pkg::pix_t [KSIZE-1:0] mem [LB_DEPTH];

  logic                           acc_r;
  logic [AW-1:0]                  col_r;
  logic [SLW-1:0]                 slot_r;
  mfer_pkg::pix_t                 pix_r;
  mfer_pkg::pix_t [KSIZE-1:0]     rd_r;
  mfer_pkg::pix_t [KSIZE-1:0]     merged;
  mfer_pkg::pix_t [WIN-1:0]       newcol;
  mfer_pkg::pix_t [WIN-1:0][WIN-1:0] win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 1'b0;
    end else begin
      acc_r <= acc;
    end
  end

  // Each memory word is one column of the last KSIZE rows. Consecutive items
  // never address the same column, so the write back of one item never meets
  // the read of the next.
  always_ff @(posedge clk) begin
    col_r  <= col;
    slot_r <= slot;
    pix_r  <= pix;
    if (acc) begin
      rd_r <= mem[col];
    end
    if (acc_r) begin
      mem[col_r] <= merged;
    end
  end

  always_comb begin
    for (int k = 0; k < KSIZE; k++) begin
      merged[k] = (SLW'(k) == slot_r) ? pix_r : rd_r[k];
    end
  end

  always_comb begin
    logic [SLW:0] s;
    s = '0;
    for (int i = 0; i < WIN; i++) begin
      s = {1'b0, slot_r} + (SLW+1)'(KSIZE - 2 * HALF + i);
      if (s >= (SLW+1)'(KSIZE)) begin
        s = s - (SLW+1)'(KSIZE);
      end
      newcol[i] = merged[s[SLW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_r) begin
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN - 1; j++) begin
          win_r[i][j] <= win_r[i][j+1];
        end
        win_r[i][WIN-1] <= newcol[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN; j++) begin
        win[i*WIN+j] = win_r[i][j];
      end
    end
  end

endmodule
`default_nettype wire

### sv/mfer_median.sv
// Pipelined rank-select median over the window, per channel.
// Depends on mfer_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mfer_median #(
  parameter int KSIZE  = mfer_pkg::KSIZE_DEF,
  localparam int HALF  = (KSIZE - 1) / 2,
  localparam int WIN   = 2 * HALF + 1,
  localparam int NE    = WIN * WIN,
  localparam int MID   = NE / 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   tag_vld,
  input  wire mfer_pkg::job_geom_t    tag,
  input  wire mfer_pkg::pix_t [NE-1:0] win,
  output logic                        med_vld,
  output mfer_pkg::pix_t              med,
  output mfer_pkg::job_geom_t         med_tag
);

  localparam int NCH = mfer_pkg::CHANNELS;
  localparam int CW  = mfer_pkg::CH_W;

  logic [NCH-1:0][NE-1:0][NE-1:0] lt;
  logic                           a_vld_r;
  mfer_pkg::job_geom_t            a_tag_r;
  mfer_pkg::pix_t [NE-1:0]        a_val_r;
  logic [NCH-1:0][NE-1:0][NE-1:0] a_lt_r;
  logic                           b_vld_r;
  mfer_pkg::job_geom_t            b_tag_r;
  mfer_pkg::pix_t [NE-1:0]        b_val_r;
  logic [NCH-1:0][NE-1:0]         sel;
  logic [NCH-1:0][NE-1:0]         b_sel_r;

  // Ties are broken by position, so exactly one element has rank MID.
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      for (int i = 0; i < NE; i++) begin
        for (int j = 0; j < NE; j++) begin
          if (j < i) begin
            lt[c][i][j] = win[j][c*CW +: CW] <= win[i][c*CW +: CW];
          end else begin
            lt[c][i][j] = win[j][c*CW +: CW] < win[i][c*CW +: CW];
          end
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      for (int i = 0; i < NE; i++) begin
        sel[c][i] = ($countones(a_lt_r[c][i]) == MID);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= tag_vld;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_tag_r <= tag;
    a_val_r <= win;
    a_lt_r  <= lt;
    b_tag_r <= a_tag_r;
    b_val_r <= a_val_r;
    b_sel_r <= sel;
  end

  always_comb begin
    med = '0;
    for (int c = 0; c < NCH; c++) begin
      for (int i = 0; i < NE; i++) begin
        if (b_sel_r[c][i]) begin
          med[c*CW +: CW] = med[c*CW +: CW] | b_val_r[i][c*CW +: CW];
        end
      end
    end
  end

  assign med_vld = b_vld_r;
  assign med_tag = b_tag_r;

endmodule
`default_nettype wire

### sv/mfer_result_q.sv
// Result queue: job queue, position generator, result memory, release
// grants and the output register. Depends on mfer_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mfer_result_q (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          job_push,
  input  wire mfer_pkg::job_geom_t           job,
  input  wire mfer_pkg::pix_t                job_med,
  input  wire logic                          gnt_push,
  input  wire logic [mfer_pkg::GNT_W-1:0]    gnt_n,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output mfer_pkg::res_entry_t               out_ent,
  output logic                               out_last,
  output mfer_pkg::q_stat_t                  stat
);

  localparam int JPW = $clog2(mfer_pkg::JOB_DEPTH);
  localparam int GPW = $clog2(mfer_pkg::GRANT_DEPTH);
  localparam int EPW = $clog2(mfer_pkg::ENTRY_DEPTH);
  localparam int CO  = mfer_pkg::COORD_W;
  localparam int SW  = mfer_pkg::SPAN_W;
  localparam int FW  = mfer_pkg::EFF_W;
  localparam int GW  = mfer_pkg::GNT_W;

  mfer_pkg::job_geom_t  jq_geom [mfer_pkg::JOB_DEPTH];
  mfer_pkg::pix_t       jq_med  [mfer_pkg::JOB_DEPTH];
  logic [GW-1:0]        gq      [mfer_pkg::GRANT_DEPTH];
  mfer_pkg::res_entry_t emem    [mfer_pkg::ENTRY_DEPTH];

  logic [JPW:0]   jw_r, jr_r;
  logic [GPW:0]   gw_r, gr_r;
  logic [EPW:0]   ew_r, er_r;
  logic           busy_r;
  logic [CO-1:0]  g_row_r, g_c0_r;
  logic [SW-1:0]  g_cc_r, g_cspan_r;
  logic [FW-1:0]  g_left_r;
  mfer_pkg::pix_t g_med_r;
  logic [GW-1:0]  k_r;
  logic           ov_r, last_r;
  mfer_pkg::res_entry_t ent_r;

  logic take, load, is_last;
  mfer_pkg::job_geom_t hj;

  assign hj      = jq_geom[jr_r[JPW-1:0]];
  assign take    = (jw_r != jr_r) && (!busy_r || g_left_r == FW'(1));
  assign load    = (!ov_r || !out_stall) && (ew_r != er_r) && (gw_r != gr_r);
  assign is_last = (k_r + GW'(1)) == gq[gr_r[GPW-1:0]];

  always_ff @(posedge clk) begin
    if (job_push) begin
      jq_geom[jw_r[JPW-1:0]] <= job;
      jq_med[jw_r[JPW-1:0]]  <= job_med;
    end
    if (gnt_push) begin
      gq[gw_r[GPW-1:0]] <= gnt_n;
    end
  end

  // Generator walks the positions of one median in row-major order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jw_r   <= '0;
      jr_r   <= '0;
      gw_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      if (job_push) jw_r <= jw_r + 1'b1;
      if (gnt_push) gw_r <= gw_r + 1'b1;
      if (take) begin
        jr_r   <= jr_r + 1'b1;
        busy_r <= 1'b1;
      end else if (busy_r && g_left_r == FW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      g_row_r   <= hj.r0;
      g_c0_r    <= hj.c0;
      g_cc_r    <= '0;
      g_cspan_r <= hj.cspan;
      g_left_r  <= hj.eff;
      g_med_r   <= jq_med[jr_r[JPW-1:0]];
    end else if (busy_r) begin
      g_left_r <= g_left_r - 1'b1;
      if (g_cc_r == g_cspan_r - 1'b1) begin
        g_cc_r  <= '0;
        g_row_r <= g_row_r + 1'b1;
      end else begin
        g_cc_r <= g_cc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      emem[ew_r[EPW-1:0]] <= '{row: g_row_r, col: g_c0_r + CO'(g_cc_r), pix: g_med_r};
    end
    if (load) begin
      ent_r  <= emem[er_r[EPW-1:0]];
      last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ew_r <= '0;
      er_r <= '0;
      gr_r <= '0;
      k_r  <= '0;
      ov_r <= 1'b0;
    end else begin
      if (busy_r) ew_r <= ew_r + 1'b1;
      if (load) begin
        er_r <= er_r + 1'b1;
        ov_r <= 1'b1;
        if (is_last) begin
          k_r  <= '0;
          gr_r <= gr_r + 1'b1;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid    = ov_r;
  assign out_ent      = ent_r;
  assign out_last     = last_r;
  assign stat.job_pop = take;
  assign stat.gnt_pop = load && is_last;

endmodule
`default_nettype wire

### sv/median_filter_edge_replicate.sv
// Top level of the KSIZE x KSIZE median filter with edge replication.
// Depends on mfer_pkg, mfer_line_buf, mfer_median and mfer_result_q.
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | in_chan_a, in_chan_b, in_chan_c
//  out     | out_valid / out_stall | out_row, out_col, out_med_a/b/c,
//          |                       | out_run_last
//  cfg     | cfg_valid / cfg_ready | cfg_index (0 width, 1 height), cfg_data
//
// The block takes one pixel item per clock while in_stall is low. The
// position generator writes one result per cycle, so one result item per
// clock leaves the output register while out_stall is low; along a border,
// where one median fills two or more positions, the generator sets the pace
// and in_stall throttles the input.
// Reset is synchronous; the line memory needs no clearing pass.
// in_stall rises when the job queue, the grant queue or the result memory
// could not hold everything that one more item might create.
module median_filter_edge_replicate #(
  parameter int KSIZE     = mfer_pkg::KSIZE_DEF,
  parameter int MAX_WIDTH = mfer_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [mfer_pkg::CH_W-1:0]       in_chan_a,
  input  wire logic [mfer_pkg::CH_W-1:0]       in_chan_b,
  input  wire logic [mfer_pkg::CH_W-1:0]       in_chan_c,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [mfer_pkg::COORD_W-1:0]         out_row,
  output logic [mfer_pkg::COORD_W-1:0]         out_col,
  output logic [mfer_pkg::CH_W-1:0]            out_med_a,
  output logic [mfer_pkg::CH_W-1:0]            out_med_b,
  output logic [mfer_pkg::CH_W-1:0]            out_med_c,
  output logic                                 out_run_last,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [0:0]                      cfg_index,
  input  wire logic [mfer_pkg::DIM_W-1:0]      cfg_data
);

  localparam int HALF     = (KSIZE - 1) / 2;
  localparam int WIN      = 2 * HALF + 1;
  localparam int NE       = WIN * WIN;
  localparam int LB_DEPTH = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
  localparam int AW       = $clog2(LB_DEPTH);
  localparam int SLW      = $clog2(KSIZE);
  localparam int DW       = mfer_pkg::DIM_W;
  localparam int CO       = mfer_pkg::COORD_W;
  localparam int SW       = mfer_pkg::SPAN_W;
  localparam int FW       = mfer_pkg::EFF_W;
  localparam int GW       = mfer_pkg::GNT_W;
  localparam int QW       = mfer_pkg::VQ_W;
  localparam int OW       = $clog2(mfer_pkg::ENTRY_DEPTH + 1);
  localparam int JW       = $clog2(mfer_pkg::JOB_DEPTH + 1);
  localparam int GCW      = $clog2(mfer_pkg::GRANT_DEPTH + 1);

  // Configuration, with sizes clamped to the legal range as they are written.
  logic [DW-1:0] w_r, h_r, cfg_w, cfg_h;

  // Frame position and the line-store row slot of the current row.
  logic [DW-1:0]  col_r;
  logic [CO-1:0]  row_r;
  logic [SLW-1:0] slot_r;

  // Queue bookkeeping: vq_r mirrors the number of results waiting for
  // release; the other counters bound what the downstream buffers hold.
  logic [QW-1:0]  vq_r;
  logic [OW-1:0]  owed_r;
  logic [JW-1:0]  jobs_r;
  logic [GCW-1:0] gnts_r;

  logic                p1_vld_r, p2_vld_r;
  mfer_pkg::job_geom_t p1_geom_r, p2_geom_r;

  logic                acc, out_acc;
  logic                wrap0, is_job, rlo, rhi, clo, chi;
  logic [DW-1:0]       col_e, col_p, col_n, cm;
  logic [DW-1:0]       row_a, row_p;
  logic [CO-1:0]       row_e, row_n, m;
  logic [SLW-1:0]      slot_a, slot_e, slot_n;
  logic [SW-1:0]       rspan, cspan;
  logic [FW-1:0]       cnt, eff;
  logic [QW-1:0]       avail, tot, vq_nxt;
  logic [GW-1:0]       n_rel;
  mfer_pkg::job_geom_t geom;

  mfer_pkg::pix_t [NE-1:0] win;
  logic                    med_vld;
  mfer_pkg::pix_t          med;
  mfer_pkg::job_geom_t     med_tag;
  mfer_pkg::res_entry_t    out_ent;
  mfer_pkg::q_stat_t       qstat;

  function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] s);
    return (s == SLW'(KSIZE - 1)) ? '0 : s + 1'b1;
  endfunction

  assign cfg_ready = 1'b1;
  assign acc       = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  always_comb begin
    cfg_w = cfg_data;
    if (cfg_data < DW'(WIN)) begin
      cfg_w = DW'(WIN);
    end else if ({2'b0, cfg_data} > (DW+2)'(MAX_WIDTH)) begin
      cfg_w = DW'(MAX_WIDTH);
    end
    cfg_h = cfg_data;
    if (cfg_data < DW'(WIN)) begin
      cfg_h = DW'(WIN);
    end else if (cfg_data > DW'(mfer_pkg::MAX_HEIGHT)) begin
      cfg_h = DW'(mfer_pkg::MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= mfer_pkg::WIDTH_RST;
      h_r <= mfer_pkg::HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mfer_pkg::REG_IMAGE_WIDTH:  w_r <= cfg_w;
        mfer_pkg::REG_IMAGE_HEIGHT: h_r <= cfg_h;
      endcase
    end
  end

  // Position of this item. A size reduced between frames can leave the
  // counters beyond the new size; they then wrap before the pixel is stored.
  always_comb begin
    wrap0  = col_r >= w_r;
    col_e  = wrap0 ? '0 : col_r;
    row_a  = wrap0 ? {1'b0, row_r} + 1'b1 : {1'b0, row_r};
    slot_a = wrap0 ? slot_inc(slot_r) : slot_r;
    if (row_a >= h_r) begin
      row_e  = '0;
      slot_e = '0;
    end else begin
      row_e  = row_a[CO-1:0];
      slot_e = slot_a;
    end
  end

  // Which output positions the median of this window fills. The window's
  // center copies itself outward by HALF on each edge it borders.
  always_comb begin
    is_job = (row_e >= CO'(2 * HALF)) && (col_e >= DW'(2 * HALF));
    m      = row_e - CO'(HALF);
    cm     = col_e - DW'(HALF);
    rlo    = m == CO'(HALF);
    rhi    = {1'b0, m} == h_r - DW'(HALF + 1);
    clo    = cm == DW'(HALF);
    chi    = cm == w_r - DW'(HALF + 1);
    rspan  = SW'(1) + (rlo ? SW'(HALF) : '0) + (rhi ? SW'(HALF) : '0);
    cspan  = SW'(1) + (clo ? SW'(HALF) : '0) + (chi ? SW'(HALF) : '0);
    cnt    = FW'(rspan) * FW'(cspan);
    avail  = QW'(mfer_pkg::QDEPTH) - vq_r;
    if (!is_job) begin
      eff = '0;
    end else if (QW'(cnt) < avail) begin
      eff = cnt;
    end else begin
      eff = avail[FW-1:0];
    end
    tot    = vq_r + QW'(eff);
    n_rel  = (tot > QW'(mfer_pkg::MAX_RESULTS)) ? GW'(mfer_pkg::MAX_RESULTS) : tot[GW-1:0];
    vq_nxt = tot - QW'(n_rel);
    geom.r0    = rlo ? '0 : m;
    geom.c0    = clo ? '0 : cm[CO-1:0];
    geom.cspan = cspan;
    geom.eff   = eff;
  end

  always_comb begin
    col_p = col_e + 1'b1;
    row_p = {1'b0, row_e} + 1'b1;
    if (col_p >= w_r) begin
      col_n = '0;
      if (row_p >= h_r) begin
        row_n  = '0;
        slot_n = '0;
      end else begin
        row_n  = row_p[CO-1:0];
        slot_n = slot_inc(slot_e);
      end
    end else begin
      col_n  = col_p;
      row_n  = row_e;
      slot_n = slot_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      slot_r   <= '0;
      vq_r     <= '0;
      owed_r   <= '0;
      jobs_r   <= '0;
      gnts_r   <= '0;
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      if (acc) begin
        col_r  <= col_n;
        row_r  <= row_n;
        slot_r <= slot_n;
        vq_r   <= vq_nxt;
      end
      owed_r   <= owed_r + (acc ? OW'(eff) : '0) - (out_acc ? OW'(1) : '0);
      jobs_r   <= jobs_r + ((acc && eff != '0) ? JW'(1) : '0)
                  - (qstat.job_pop ? JW'(1) : '0);
      gnts_r   <= gnts_r + ((acc && n_rel != '0) ? GCW'(1) : '0)
                  - (qstat.gnt_pop ? GCW'(1) : '0);
      p1_vld_r <= acc && eff != '0;
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_geom_r <= geom;
    p2_geom_r <= p1_geom_r;
  end

  assign in_stall = (owed_r > OW'(mfer_pkg::ENTRY_DEPTH - NE))
                 || (jobs_r == JW'(mfer_pkg::JOB_DEPTH))
                 || (gnts_r == GCW'(mfer_pkg::GRANT_DEPTH));

  mfer_line_buf #(
    .KSIZE     (KSIZE),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .col   (col_e[AW-1:0]),
    .slot  (slot_e),
    .pix   ({in_chan_c, in_chan_b, in_chan_a}),
    .win   (win)
  );

  mfer_median #(
    .KSIZE (KSIZE)
  ) u_median (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_vld (p2_vld_r),
    .tag     (p2_geom_r),
    .win     (win),
    .med_vld (med_vld),
    .med     (med),
    .med_tag (med_tag)
  );

  mfer_result_q u_result_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_push  (med_vld),
    .job       (med_tag),
    .job_med   (med),
    .gnt_push  (acc && n_rel != '0),
    .gnt_n     (n_rel),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_ent   (out_ent),
    .out_last  (out_run_last),
    .stat      (qstat)
  );

  assign out_row   = out_ent.row;
  assign out_col   = out_ent.col;
  assign out_med_a = out_ent.pix[7:0];
  assign out_med_b = out_ent.pix[15:8];
  assign out_med_c = out_ent.pix[23:16];

endmodule
`default_nettype wire
